// ----- rtl/clut_pkg.sv -----
// Shared types, constants and the channel expansion table of the texel decoder.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package clut_pkg;

	// Video memory geometry. Both figures are powers of two, so byte addresses
	// wrap by simply dropping the upper bits.
	localparam int ROW_BYTES     = 2048;
	localparam int MEMORY_ROWS   = 512;
	localparam int MEM_BYTES     = ROW_BYTES * MEMORY_ROWS;
	localparam int MEM_HALFWORDS = MEM_BYTES / 2;
	localparam int BYTE_AW       = $clog2(MEM_BYTES);
	localparam int HALF_AW       = BYTE_AW - 1;

	// Texture page and color table address units.
	localparam int PAGE_X_UNIT   = 128;
	localparam int CLUT_X_UNIT   = 32;

	// Depth of the command queue between front and back.
	localparam int QUEUE_DEPTH   = 4;

	// Configuration register indexes.
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 16;
	localparam logic [CFG_IDX_W-1:0] REG_TPAGE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PALETTE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BLEND   = 2'd2;

	// Request kinds.
	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_FETCH = 1'b1;

	// Color depth field of the texture page register.
	localparam logic [1:0] DEPTH_4BIT     = 2'd0;
	localparam logic [1:0] DEPTH_8BIT     = 2'd1;
	localparam logic [1:0] DEPTH_15BIT    = 2'd2;
	localparam logic [1:0] DEPTH_RESERVED = 2'd3;

	// Opacity codes.
	localparam logic [7:0] ALPHA_CLEAR  = 8'd0;
	localparam logic [7:0] ALPHA_HALF   = 8'd128;
	localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

	// Rounded 5-bit to 8-bit channel expansion, (c * 255 + 15) / 31.
	localparam logic [7:0] EXPAND5 [32] = '{
		8'd0,   8'd8,   8'd16,  8'd25,  8'd33,  8'd41,  8'd49,  8'd58,
		8'd66,  8'd74,  8'd82,  8'd90,  8'd99,  8'd107, 8'd115, 8'd123,
		8'd132, 8'd140, 8'd148, 8'd156, 8'd165, 8'd173, 8'd181, 8'd189,
		8'd197, 8'd206, 8'd214, 8'd222, 8'd230, 8'd239, 8'd247, 8'd255
	};

	// Work the back end has to do for one queued request.
	typedef enum logic [2:0] {
		OP_WRITE,
		OP_DIRECT,
		OP_INDEX4,
		OP_INDEX8,
		OP_RESERVED
	} clut_op_t;

	// One queued command, classified and addressed by the front end.
	typedef struct packed {
		clut_op_t           op;
		logic [BYTE_AW-1:0] addr;
		logic [15:0]        wdata;
		logic               nib_hi;
		logic [BYTE_AW-1:0] clut_base;
		logic               blend;
	} clut_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/clut_intf.sv -----
// Valid/ready channel interfaces of the texel decoder: input requests, results
// and configuration writes. Depends on clut_pkg for widths.
`default_nettype none

interface clut_in_if import clut_pkg::*; ();
	logic        valid;
	logic        ready;
	logic        kind;
	logic [18:0] write_address;
	logic [15:0] write_data;
	logic [7:0]  texel_x;
	logic [7:0]  texel_y;

	modport source (output valid, kind, write_address, write_data, texel_x, texel_y,
		input ready);
	modport sink (input valid, kind, write_address, write_data, texel_x, texel_y,
		output ready);
endinterface

interface clut_out_if import clut_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [7:0] opacity;
	logic       mode_error;

	modport source (output valid, red, green, blue, opacity, mode_error, input ready);
	modport sink (input valid, red, green, blue, opacity, mode_error, output ready);
endinterface

interface clut_cfg_if import clut_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/clut_front.sv -----
// Front end: holds the configuration registers, accepts input requests and turns
// each into a classified, addressed command for the queue. Depends on clut_pkg.
`default_nettype none

module clut_front import clut_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	clut_cfg_if.sink       cfg,
	clut_in_if.sink        texel_in,
	input  wire logic      q_full,
	output logic           q_push,
	output clut_cmd_t      push_cmd
);

	logic [15:0] tpage_q;
	logic [14:0] palette_q;
	logic        blend_q;

	logic [1:0]  depth;
	logic [8:0]  row;
	logic [31:0] tex_base;
	logic [31:0] tex_addr;
	logic [31:0] clut_sum;

	// Configuration registers; writes to unknown indexes are dropped.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpage_q   <= '0;
			palette_q <= '0;
			blend_q   <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_TPAGE:   tpage_q   <= cfg.data;
				REG_PALETTE: palette_q <= cfg.data[14:0];
				REG_BLEND:   blend_q   <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// Accept whenever the queue has room.
	assign texel_in.ready = !q_full;
	assign q_push         = texel_in.valid && !q_full;

	// Texture and color table addresses, wrapped to the memory size.
	always_comb begin
		depth    = tpage_q[8:7];
		row      = {tpage_q[4], texel_in.texel_y};
		tex_base = 32'(row) * 32'(ROW_BYTES) + 32'(tpage_q[3:0]) * 32'(PAGE_X_UNIT);
		case (depth)
			DEPTH_4BIT:  tex_addr = tex_base + 32'(texel_in.texel_x[7:1]);
			DEPTH_8BIT:  tex_addr = tex_base + 32'(texel_in.texel_x);
			default:     tex_addr = tex_base + 32'({texel_in.texel_x, 1'b0});
		endcase
		clut_sum = 32'(palette_q[14:6]) * 32'(ROW_BYTES)
			+ 32'(palette_q[5:0]) * 32'(CLUT_X_UNIT);
	end

	// Classify the request.
	always_comb begin
		push_cmd.wdata     = texel_in.write_data;
		push_cmd.nib_hi    = texel_in.texel_x[0];
		push_cmd.clut_base = clut_sum[BYTE_AW-1:0];
		push_cmd.blend     = blend_q;
		if (texel_in.kind == KIND_WRITE) begin
			push_cmd.op   = OP_WRITE;
			push_cmd.addr = {HALF_AW'(texel_in.write_address), 1'b0};
		end else begin
			push_cmd.addr = tex_addr[BYTE_AW-1:0];
			case (depth)
				DEPTH_4BIT:  push_cmd.op = OP_INDEX4;
				DEPTH_8BIT:  push_cmd.op = OP_INDEX8;
				DEPTH_15BIT: push_cmd.op = OP_DIRECT;
				default:     push_cmd.op = OP_RESERVED;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- rtl/clut_cmd_fifo.sv -----
// Short command queue between the front end and the back end.
// Depends on clut_pkg for the command type and depth.
`default_nettype none

module clut_cmd_fifo import clut_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire clut_cmd_t push_cmd,
	output logic           full,
	input  wire logic      pop,
	output clut_cmd_t      head,
	output logic           empty
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	clut_cmd_t          slots [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full  = count_q == CNT_W'(QUEUE_DEPTH);
	assign empty = count_q == '0;
	assign head  = slots[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slots[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/clut_back.sv -----
// Back end: owns the video memory and its single port, runs writes and the
// reads of a fetch (one or two, none for a reserved depth), and holds the
// result register. Depends on clut_pkg and clut_out_if.
`default_nettype none

module clut_back import clut_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire clut_cmd_t head,
	input  wire logic      q_empty,
	output logic           q_pop,
	clut_out_if.source     texel_out
);

	logic [15:0]        vram [MEM_HALFWORDS];
	logic [15:0]        rd_data_q;

	logic               valid_s1;
	logic               phase2_s1;
	clut_op_t           op_s1;
	logic               addr_lo_s1;
	logic               nib_hi_s1;
	logic               blend_s1;
	logic [BYTE_AW-1:0] clut_base_s1;

	logic               out_valid_q;
	logic [7:0]         red_q;
	logic [7:0]         green_q;
	logic [7:0]         blue_q;
	logic [7:0]         opacity_q;
	logic               mode_error_q;

	logic               out_take;
	logic               s1_second;
	logic               s1_final;
	logic               s1_free;
	logic               head_write;
	logic               head_go;
	logic               mem_we;
	logic               rd_en;
	logic [HALF_AW-1:0] rd_addr;
	logic [7:0]         texel_byte;
	logic [7:0]         clut_index;
	logic [BYTE_AW-1:0] clut_addr;

	// Port arbitration: a pending color table read has the port, otherwise
	// the queue head goes when its destination is free.
	always_comb begin
		out_take   = !out_valid_q || texel_out.ready;
		s1_second  = valid_s1 && !phase2_s1 && (op_s1 inside {OP_INDEX4, OP_INDEX8});
		s1_final   = valid_s1 && !s1_second;
		s1_free    = !valid_s1 || (s1_final && out_take);
		head_write = head.op == OP_WRITE;
		head_go    = !q_empty && !s1_second && (head_write || s1_free);
		q_pop      = head_go;
		mem_we     = head_go && head_write;
		rd_en      = s1_second
			|| (head_go && (head.op inside {OP_DIRECT, OP_INDEX4, OP_INDEX8}));
	end

	// Color table address from the index just read.
	always_comb begin
		texel_byte = addr_lo_s1 ? rd_data_q[15:8] : rd_data_q[7:0];
		if (op_s1 == OP_INDEX4) begin
			clut_index = {4'b0000, nib_hi_s1 ? texel_byte[7:4] : texel_byte[3:0]};
		end else begin
			clut_index = texel_byte;
		end
		clut_addr = clut_base_s1 + BYTE_AW'({clut_index, 1'b0});
		rd_addr   = s1_second ? clut_addr[BYTE_AW-1:1] : head.addr[BYTE_AW-1:1];
	end

	// Video memory, one access per cycle, registered read data.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			vram[head.addr[BYTE_AW-1:1]] <= head.wdata;
		end
		if (rd_en) begin
			rd_data_q <= vram[rd_addr];
		end
	end

	// Fetch in flight: control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			phase2_s1 <= 1'b0;
		end else if (head_go && !head_write) begin
			valid_s1  <= 1'b1;
			phase2_s1 <= 1'b0;
		end else if (s1_second) begin
			phase2_s1 <= 1'b1;
		end else if (s1_final && out_take) begin
			valid_s1 <= 1'b0;
		end
	end

	// Fetch in flight: payload.
	always_ff @(posedge clk) begin
		if (head_go && !head_write) begin
			op_s1        <= head.op;
			addr_lo_s1   <= head.addr[0];
			nib_hi_s1    <= head.nib_hi;
			blend_s1     <= head.blend;
			clut_base_s1 <= head.clut_base;
		end
	end

	// Result register: valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_take) begin
			out_valid_q <= s1_final;
		end
	end

	// Result register: color expansion and opacity.
	always_ff @(posedge clk) begin
		if (out_take && s1_final) begin
			if (op_s1 == OP_RESERVED) begin
				red_q        <= '0;
				green_q      <= '0;
				blue_q       <= '0;
				opacity_q    <= ALPHA_CLEAR;
				mode_error_q <= 1'b1;
			end else begin
				red_q        <= EXPAND5[rd_data_q[4:0]];
				green_q      <= EXPAND5[rd_data_q[9:5]];
				blue_q       <= EXPAND5[rd_data_q[14:10]];
				mode_error_q <= 1'b0;
				if (rd_data_q == '0) begin
					opacity_q <= ALPHA_CLEAR;
				end else if (blend_s1 && rd_data_q[15] && (rd_data_q[14:0] != '0)) begin
					opacity_q <= ALPHA_HALF;
				end else begin
					opacity_q <= ALPHA_OPAQUE;
				end
			end
		end
	end

	assign texel_out.valid      = out_valid_q;
	assign texel_out.red        = red_q;
	assign texel_out.green      = green_q;
	assign texel_out.blue       = blue_q;
	assign texel_out.opacity    = opacity_q;
	assign texel_out.mode_error = mode_error_q;

endmodule

`default_nettype wire

// ----- rtl/clut_texture_texel_decode.sv -----
// Indexed texel decoder over a halfword video memory.
// Channels: texel_in carries write requests (kind 0) that store one halfword and
// fetch requests (kind 1) that decode one texel of the current texture page;
// texel_out carries one result per fetch and nothing for a write; cfg writes
// the texture page, color table location and blend enable registers, and is
// always ready. Configure only while no request is in flight.
// Throughput is set by the single video memory port: one write, direct-color
// fetch or reserved-depth fetch per cycle while the receiver keeps up, and an
// indexed fetch holds it for an index read and then a color table read.
// A fetch is stored in the queue, then held in the fetch-in-flight stage for
// its memory reads, then captured in the result register.
// A four-entry command queue parts the front end from the memory side, and a
// result register parts the memory side from the receiver: while the
// receiver stalls, requests keep entering until the queue fills, and queued
// writes still go to memory until a fetch waits at the head of the queue.
// Reset clears the configuration registers, the queue and the valid flags;
// video memory is not cleared and must be written before it is read.
// Depends on clut_pkg, the interfaces, clut_front, clut_cmd_fifo, clut_back.
`default_nettype none

module clut_texture_texel_decode import clut_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	clut_cfg_if.sink   cfg,
	clut_in_if.sink    texel_in,
	clut_out_if.source texel_out
);

	logic      q_push;
	logic      q_full;
	logic      q_pop;
	logic      q_empty;
	clut_cmd_t push_cmd;
	clut_cmd_t head;

	// Accept and classify.
	clut_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.texel_in (texel_in),
		.q_full   (q_full),
		.q_push   (q_push),
		.push_cmd (push_cmd)
	);

	// Command queue.
	clut_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.head     (head),
		.empty    (q_empty)
	);

	// Memory and result side.
	clut_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.texel_out (texel_out)
	);

	// The back end only takes commands that are really queued.
	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("command popped from an empty queue");

	// A reserved-depth result carries no color.
	a_reserved_zero: assert property (@(posedge clk) disable iff (!arst_n)
		texel_out.valid && texel_out.mode_error |->
			texel_out.red == 8'd0 && texel_out.green == 8'd0
			&& texel_out.blue == 8'd0 && texel_out.opacity == ALPHA_CLEAR)
		else $error("reserved-depth result with non-zero color");

	// Opacity is always one of the three codes.
	a_opacity_code: assert property (@(posedge clk) disable iff (!arst_n)
		texel_out.valid |-> texel_out.opacity == ALPHA_CLEAR
			|| texel_out.opacity == ALPHA_HALF || texel_out.opacity == ALPHA_OPAQUE)
		else $error("opacity outside its three codes");

endmodule

`default_nettype wire
